>>> hw/rtl/thnc_pkg.sv
// Shared constants, codes and types for the tagged hex name collector.
package thnc_pkg;

  localparam int NAME_MAX  = 32;
  localparam int NAME_AW   = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;
  localparam int CNT_W     = $clog2(NAME_MAX + 1);
  localparam int RAM_AW    = NAME_AW + 1;
  localparam int RAM_DEPTH = 1 << RAM_AW;

  localparam int BYTE_W  = 8;
  localparam int BSIZE_W = 21;
  localparam int OFF_W   = 20;
  localparam int TOTAL_W = 21;
  localparam int RUN_W   = 7;
  localparam int PADDR_W = 2;
  localparam int PDATA_W = 32;

  localparam logic [BSIZE_W-1:0] BUF_LIMIT = 21'h100000;
  localparam logic [TOTAL_W-1:0] NEED_SAT  = 21'h1FFFFF;
  localparam logic [RUN_W-1:0]   RUN_SAT   = 7'd127;

  localparam logic [PADDR_W-1:0] REG_BUFFER_SIZE = 2'd0;

  typedef enum logic [1:0] {
    KIND_WRITE    = 2'd0,
    KIND_DONE     = 2'd1,
    KIND_OVERFLOW = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    MODE_OUT,
    MODE_TAG,
    MODE_NAME
  } mode_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_NAME,
    BK_NUL,
    BK_FINAL
  } bk_state_t;

  // One unit of work for the back end: an optional name copy, then an optional final.
  typedef struct packed {
    logic               has_name;
    logic               bank;
    logic [CNT_W-1:0]   n;
    logic [OFF_W-1:0]   base;
    logic               has_final;
    kind_t              fkind;
    logic [TOTAL_W-1:0] total;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } bank_rel_t;

endpackage

>>> hw/rtl/tagged_hex_name_collector.sv
// Top level: config register, front end, command queue, name store RAM, back end.
// Input: one body byte per cycle; the input stalls only while the command queue is
// full or the name store bank being decoded into is still being copied out.
// Output: a name of n bytes plays out as n+1 writes, one per cycle while out_stall is low;
// a final result is one more transfer; the back end passes through BK_IDLE between commands.
// Reset (rst_n, synchronous): scanner, totals, queue and output are cleared and
// buffer_size reads 0; the name store is not cleared and needs no clearing pass.
module tagged_hex_name_collector import thnc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [BYTE_W-1:0]   in_body_byte,
  input  logic                in_end_of_body,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_kind,
  output logic [OFF_W-1:0]    out_buf_offset,
  output logic [BYTE_W-1:0]   out_data_byte,
  output logic [TOTAL_W-1:0]  out_total_need,
  output logic                out_last,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  logic [BSIZE_W-1:0] buffer_size_r, buffer_size_nxt;

  logic               push, q_full, q_valid, q_pop;
  cmd_t               push_cmd, q_head;
  bank_rel_t          rel;
  logic               ram_we;
  logic [RAM_AW-1:0]  ram_waddr, ram_raddr;
  logic [BYTE_W-1:0]  ram_wdata, ram_rdata;

  assign pready = 1'b1;

  // single register: every write transfer lands in buffer_size
  always_comb begin
    buffer_size_nxt = buffer_size_r;
    if (psel && penable && pwrite && pready) begin
      buffer_size_nxt = pwdata[BSIZE_W-1:0];
    end
  end

  assign prdata = (paddr == REG_BUFFER_SIZE) ? PDATA_W'(buffer_size_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buffer_size_r <= '0;
    end else begin
      buffer_size_r <= buffer_size_nxt;
    end
  end

  thnc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_body_byte   (in_body_byte),
    .in_end_of_body (in_end_of_body),
    .in_stall       (in_stall),
    .buffer_size    (buffer_size_r),
    .push           (push),
    .cmd            (push_cmd),
    .q_full         (q_full),
    .rel            (rel),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata)
  );

  thnc_cmd_q u_cmd_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .full     (q_full),
    .q_valid  (q_valid),
    .head     (q_head)
  );

  thnc_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RAM_DEPTH)
  ) u_name_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  thnc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .rel            (rel),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_buf_offset (out_buf_offset),
    .out_data_byte  (out_data_byte),
    .out_total_need (out_total_need),
    .out_last       (out_last)
  );

endmodule

>>> hw/rtl/thnc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module thnc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/thnc_front.sv
// Front end: tag scanner, hex decoder into a banked name store, and command issue.
module thnc_front import thnc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [BYTE_W-1:0]   in_body_byte,
  input  logic                in_end_of_body,
  output logic                in_stall,
  input  logic [BSIZE_W-1:0]  buffer_size,
  output logic                push,
  output cmd_t                cmd,
  input  logic                q_full,
  input  bank_rel_t           rel,
  output logic                ram_we,
  output logic [RAM_AW-1:0]   ram_waddr,
  output logic [BYTE_W-1:0]   ram_wdata
);

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF_HX = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_X     = 8'h78;

  // bit 4 flags a hex digit, bits 3..0 hold its value
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= CH_0 && c <= CH_9) begin
      r = {1'b1, 4'(c - CH_0)};
    end else if (c >= CH_LA && c <= CH_LF_HX) begin
      r = {1'b1, 4'(c - CH_LA + 8'd10)};
    end else if (c >= CH_UA && c <= CH_UF) begin
      r = {1'b1, 4'(c - CH_UA + 8'd10)};
    end
    return r;
  endfunction

  function automatic logic [7:0] marker_char(input logic [1:0] i);
    logic [7:0] r;
    case (i)
      2'd0:    r = CH_B;
      2'd1:    r = CH_X;
      default: r = CH_LA;
    endcase
    return r;
  endfunction

  mode_t              mode_r, mode_nxt;
  logic [RUN_W-1:0]   run_r, run_nxt;
  logic               ok_r, ok_nxt;
  logic [4:0]         hn_r, hn_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [TOTAL_W-1:0] need_r, need_nxt;
  logic               ovf_r, ovf_nxt;
  logic               wb_r, wb_nxt;
  logic [1:0]         busy_r, busy_nxt;

  logic               accept;
  logic [7:0]         c;
  logic               is_term;
  logic [4:0]         hx;

  logic               do_start, do_feed, fin_term;
  logic [RUN_W-1:0]   b_run, f_run, s_run;
  logic               b_ok, f_ok, s_ok;
  logic [4:0]         b_hn, f_hn, s_hn;
  logic [CNT_W-1:0]   b_cnt, f_cnt, s_cnt;
  logic               f_we;

  logic               finish, name_ok, fits;
  logic [BSIZE_W-1:0] size;
  logic [TOTAL_W:0]   sum;
  logic [TOTAL_W-1:0] need_a;
  logic               ovf_a;
  mode_t              mode_a;

  assign in_stall = q_full | busy_r[wb_r];
  assign accept   = in_valid & ~in_stall;
  assign c        = in_body_byte;
  assign is_term  = (c == CH_GT) || (c == CH_SLASH) || (c == CH_SPACE) ||
                    (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  assign hx       = hex_decode(c);

  // scan mode transition and which actions the byte triggers
  always_comb begin
    mode_a   = mode_r;
    do_start = 1'b0;
    do_feed  = 1'b0;
    fin_term = 1'b0;
    case (mode_r)
      MODE_OUT: begin
        if (c == CH_LT) mode_a = MODE_TAG;
      end
      MODE_TAG: begin
        if (c == CH_SLASH || c == CH_BANG || c == CH_QUEST) begin
          mode_a = MODE_OUT;
        end else if (c == CH_LT) begin
          mode_a = MODE_TAG;
        end else if (is_term) begin
          mode_a = MODE_OUT;
        end else begin
          do_start = 1'b1;
          do_feed  = 1'b1;
          mode_a   = MODE_NAME;
        end
      end
      MODE_NAME: begin
        if (c == CH_LT) begin
          mode_a = MODE_TAG;
        end else if (is_term) begin
          fin_term = 1'b1;
          mode_a   = MODE_OUT;
        end else begin
          do_feed = 1'b1;
        end
      end
      default: mode_a = MODE_OUT;
    endcase
  end

  // one name character into the candidate
  always_comb begin
    b_run = do_start ? '0 : run_r;
    b_ok  = do_start ? 1'b1 : ok_r;
    b_hn  = do_start ? '0 : hn_r;
    b_cnt = do_start ? '0 : cnt_r;
    f_run = b_run;
    f_ok  = b_ok;
    f_hn  = b_hn;
    f_cnt = b_cnt;
    f_we  = 1'b0;
    if (c == CH_COLON) begin
      // a prefix ends here; the local name restarts
      f_run = '0;
      f_ok  = 1'b1;
      f_hn  = '0;
      f_cnt = '0;
    end else begin
      if (b_ok) begin
        if (b_run < RUN_W'(3)) begin
          if (c != marker_char(b_run[1:0])) f_ok = 1'b0;
        end else if (!hx[4]) begin
          f_ok = 1'b0;
        end else if (b_hn[4]) begin
          if (b_cnt >= CNT_W'(NAME_MAX)) begin
            f_ok = 1'b0;
          end else begin
            f_we  = 1'b1;
            f_cnt = b_cnt + CNT_W'(1);
            f_hn  = '0;
          end
        end else begin
          f_hn = hx;
        end
      end
      if (b_run != RUN_SAT) f_run = b_run + RUN_W'(1);
    end
  end

  assign s_run = do_feed ? f_run : run_r;
  assign s_ok  = do_feed ? f_ok  : ok_r;
  assign s_hn  = do_feed ? f_hn  : hn_r;
  assign s_cnt = do_feed ? f_cnt : cnt_r;

  assign ram_we    = accept & do_feed & f_we;
  assign ram_waddr = {wb_r, b_cnt[NAME_AW-1:0]};
  assign ram_wdata = {b_hn[3:0], hx[3:0]};

  assign finish  = fin_term || (in_end_of_body && mode_a == MODE_NAME);
  assign name_ok = s_ok && (s_run > RUN_W'(3)) && !s_hn[4] && (s_cnt != '0);
  assign size    = (buffer_size > BUF_LIMIT) ? BUF_LIMIT : buffer_size;
  assign sum     = {1'b0, need_r} + (TOTAL_W+1)'(s_cnt) + (TOTAL_W+1)'(1);
  assign fits    = (size != '0) && (sum <= (TOTAL_W+1)'(size));

  always_comb begin
    need_a        = need_r;
    ovf_a         = ovf_r;
    cmd           = '0;
    cmd.bank      = wb_r;
    cmd.n         = s_cnt;
    cmd.base      = need_r[OFF_W-1:0];
    cmd.fkind     = KIND_DONE;
    if (finish && name_ok) begin
      if (fits) begin
        cmd.has_name = 1'b1;
      end else if (size != '0) begin
        ovf_a = 1'b1;
      end
      need_a = (sum > (TOTAL_W+1)'(NEED_SAT)) ? NEED_SAT : sum[TOTAL_W-1:0];
    end
    if (in_end_of_body) begin
      cmd.has_final = 1'b1;
      cmd.fkind     = ovf_a ? KIND_OVERFLOW : KIND_DONE;
      cmd.total     = need_a;
    end
  end

  assign push = accept & (cmd.has_name | cmd.has_final);

  always_comb begin
    mode_nxt = mode_r;
    run_nxt  = run_r;
    ok_nxt   = ok_r;
    hn_nxt   = hn_r;
    cnt_nxt  = cnt_r;
    need_nxt = need_r;
    ovf_nxt  = ovf_r;
    wb_nxt   = wb_r;
    busy_nxt = busy_r;
    if (rel.valid) busy_nxt[rel.bank] = 1'b0;
    if (accept) begin
      mode_nxt = mode_a;
      run_nxt  = s_run;
      ok_nxt   = s_ok;
      hn_nxt   = s_hn;
      cnt_nxt  = s_cnt;
      need_nxt = need_a;
      ovf_nxt  = ovf_a;
      if (cmd.has_name) begin
        busy_nxt[wb_r] = 1'b1;
        wb_nxt         = ~wb_r;
      end
      if (in_end_of_body) begin
        mode_nxt = MODE_OUT;
        run_nxt  = '0;
        ok_nxt   = 1'b0;
        hn_nxt   = '0;
        cnt_nxt  = '0;
        need_nxt = '0;
        ovf_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_OUT;
      run_r  <= '0;
      ok_r   <= 1'b0;
      hn_r   <= '0;
      cnt_r  <= '0;
      need_r <= '0;
      ovf_r  <= 1'b0;
      wb_r   <= 1'b0;
      busy_r <= '0;
    end else begin
      mode_r <= mode_nxt;
      run_r  <= run_nxt;
      ok_r   <= ok_nxt;
      hn_r   <= hn_nxt;
      cnt_r  <= cnt_nxt;
      need_r <= need_nxt;
      ovf_r  <= ovf_nxt;
      wb_r   <= wb_nxt;
      busy_r <= busy_nxt;
    end
  end

endmodule

>>> hw/rtl/thnc_cmd_q.sv
// Two-entry command queue between the front and back ends.
module thnc_cmd_q import thnc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic q_valid,
  output cmd_t head
);

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = 1;

  cmd_t             entry_r [Q_DEPTH];
  logic [Q_AW-1:0]  wptr_r, wptr_nxt;
  logic [Q_AW-1:0]  rptr_r, rptr_nxt;
  logic [Q_AW:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign q_valid = (count_r != '0);
  assign head    = entry_r[rptr_r];
  assign do_push = push & ~full;
  assign do_pop  = pop & q_valid;

  always_comb begin
    wptr_nxt  = do_push ? wptr_r + Q_AW'(1) : wptr_r;
    rptr_nxt  = do_pop ? rptr_r + Q_AW'(1) : rptr_r;
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + (Q_AW+1)'(1);
    if (do_pop && !do_push) count_nxt = count_r - (Q_AW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

>>> hw/rtl/thnc_back.sv
// Back end: plays out queued commands as buffer writes and final results.
module thnc_back import thnc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  cmd_t                q_head,
  output logic                q_pop,
  output bank_rel_t           rel,
  output logic [RAM_AW-1:0]   ram_raddr,
  input  logic [BYTE_W-1:0]   ram_rdata,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_kind,
  output logic [OFF_W-1:0]    out_buf_offset,
  output logic [BYTE_W-1:0]   out_data_byte,
  output logic [TOTAL_W-1:0]  out_total_need,
  output logic                out_last
);

  bk_state_t          state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [NAME_AW-1:0] idx_r, idx_nxt;

  logic               valid_r, valid_nxt;
  kind_t              kind_r, kind_nxt;
  logic [OFF_W-1:0]   off_r, off_nxt;
  logic [BYTE_W-1:0]  data_r, data_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic               last_r, last_nxt;

  logic               slot_free;

  assign slot_free = ~valid_r | ~out_stall;
  // address the next index so read data lines up with idx_r
  assign ram_raddr = {cmd_nxt.bank, idx_nxt};

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    idx_nxt   = idx_r;
    q_pop     = 1'b0;
    rel       = '0;
    valid_nxt = valid_r & out_stall;
    kind_nxt  = kind_r;
    off_nxt   = off_r;
    data_nxt  = data_r;
    total_nxt = total_r;
    last_nxt  = last_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_head;
          idx_nxt   = '0;
          state_nxt = q_head.has_name ? BK_NAME : BK_FINAL;
        end
      end
      BK_NAME: begin
        if (slot_free) begin
          valid_nxt = 1'b1;
          kind_nxt  = KIND_WRITE;
          off_nxt   = cmd_r.base + OFF_W'(idx_r);
          data_nxt  = ram_rdata;
          total_nxt = '0;
          last_nxt  = 1'b0;
          if (CNT_W'(idx_r) == cmd_r.n - CNT_W'(1)) begin
            state_nxt = BK_NUL;
          end else begin
            idx_nxt = idx_r + NAME_AW'(1);
          end
        end
      end
      BK_NUL: begin
        if (slot_free) begin
          valid_nxt = 1'b1;
          kind_nxt  = KIND_WRITE;
          off_nxt   = cmd_r.base + OFF_W'(cmd_r.n);
          data_nxt  = '0;
          total_nxt = '0;
          last_nxt  = ~cmd_r.has_final;
          rel.valid = 1'b1;
          rel.bank  = cmd_r.bank;
          state_nxt = cmd_r.has_final ? BK_FINAL : BK_IDLE;
        end
      end
      BK_FINAL: begin
        if (slot_free) begin
          valid_nxt = 1'b1;
          kind_nxt  = cmd_r.fkind;
          off_nxt   = '0;
          data_nxt  = '0;
          total_nxt = cmd_r.total;
          last_nxt  = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    idx_r   <= idx_nxt;
    kind_r  <= kind_nxt;
    off_r   <= off_nxt;
    data_r  <= data_nxt;
    total_r <= total_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid      = valid_r;
  assign out_kind       = kind_r;
  assign out_buf_offset = off_r;
  assign out_data_byte  = data_r;
  assign out_total_need = total_r;
  assign out_last       = last_r;

endmodule

>>> test/thnc_name_checker.sv
// Scoreboard for the tagged hex name collector: predicts name writes and finals, checks them.
module thnc_name_checker import thnc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [BYTE_W-1:0]  in_body_byte,
  input  logic               in_end_of_body,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [1:0]         out_kind,
  input  logic [OFF_W-1:0]   out_buf_offset,
  input  logic [BYTE_W-1:0]  out_data_byte,
  input  logic [TOTAL_W-1:0] out_total_need,
  input  logic               out_last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output int                 mismatches,
  output int                 outstanding
);

  localparam logic [7:0]  CH_TAB = 8'h09;
  localparam logic [7:0]  CH_LF  = 8'h0A;
  localparam logic [7:0]  CH_CR  = 8'h0D;
  localparam logic [23:0] MARKER = "bxa";

  typedef struct packed {
    kind_t              kind;
    logic [OFF_W-1:0]   off;
    logic [BYTE_W-1:0]  data;
    logic [TOTAL_W-1:0] total;
    logic               last;
  } name_result_t;

  // predictor state
  logic [BSIZE_W-1:0] buf_size;
  mode_t              mode;
  int                 run_len;
  logic               cand_ok;
  logic               nib_pending;
  logic [3:0]         nib_val;
  logic [7:0]         name_buf [NAME_MAX];
  int                 dec_cnt;
  int                 need_sum;
  logic               overflow;

  name_result_t step_q[$];
  name_result_t name_result_q[$];
  int           err_cnt = 0;

  function automatic int hex_val(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a" + 8'd10);
    if (c >= "A" && c <= "F") return int'(c - "A" + 8'd10);
    return -1;
  endfunction

  function automatic logic is_term(input logic [7:0] c);
    return c == ">" || c == "/" || c == " " || c == CH_TAB || c == CH_CR || c == CH_LF;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    err_cnt++;
    $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  task automatic push_result(input kind_t kind, input int off, input logic [7:0] data,
                             input int total);
    name_result_t r;
    r.kind  = kind;
    r.off   = off[OFF_W-1:0];
    r.data  = data;
    r.total = total[TOTAL_W-1:0];
    r.last  = 1'b0;
    step_q.push_back(r);
  endtask

  task automatic begin_run();
    run_len     = 0;
    cand_ok     = 1'b1;
    nib_pending = 1'b0;
    nib_val     = '0;
    dec_cnt     = 0;
  endtask

  task automatic clear_scan();
    mode        = MODE_OUT;
    run_len     = 0;
    cand_ok     = 1'b0;
    nib_pending = 1'b0;
    nib_val     = '0;
    dec_cnt     = 0;
    need_sum    = 0;
    overflow    = 1'b0;
  endtask

  task automatic feed_char(input logic [7:0] c);
    int h;
    h = hex_val(c);
    if (c == ":") begin
      // a colon restarts the local name
      begin_run();
    end else begin
      if (cand_ok) begin
        if (run_len < 3) begin
          if (c != MARKER[23 - 8*run_len -: 8]) cand_ok = 1'b0;
        end else if (h < 0) begin
          cand_ok = 1'b0;
        end else if (nib_pending) begin
          if (dec_cnt >= NAME_MAX) begin
            cand_ok = 1'b0;
          end else begin
            name_buf[dec_cnt] = {nib_val, h[3:0]};
            dec_cnt++;
            nib_pending = 1'b0;
          end
        end else begin
          nib_pending = 1'b1;
          nib_val     = h[3:0];
        end
      end
      if (run_len < int'(RUN_SAT)) run_len++;
    end
  endtask

  task automatic close_name();
    int n;
    int size;
    if (!cand_ok || run_len <= 3 || nib_pending || dec_cnt == 0) return;
    n    = dec_cnt;
    size = (buf_size > BUF_LIMIT) ? int'(BUF_LIMIT) : int'(buf_size);
    if (size != 0 && need_sum + n + 1 <= size) begin
      for (int i = 0; i < n; i++) push_result(KIND_WRITE, need_sum + i, name_buf[i], 0);
      push_result(KIND_WRITE, need_sum + n, 8'h00, 0);
    end else if (size != 0) begin
      overflow = 1'b1;
    end
    need_sum = need_sum + n + 1;
    if (need_sum > int'(NEED_SAT)) need_sum = int'(NEED_SAT);
  endtask

  task automatic scan_body_byte(input logic [7:0] c, input logic eob);
    step_q.delete();
    case (mode)
      MODE_OUT: begin
        if (c == "<") mode = MODE_TAG;
      end
      MODE_TAG: begin
        if (c == "/" || c == "!" || c == "?") mode = MODE_OUT;
        else if (c == "<") mode = MODE_TAG;
        else if (is_term(c)) mode = MODE_OUT;
        else begin
          begin_run();
          feed_char(c);
          mode = MODE_NAME;
        end
      end
      default: begin
        if (c == "<") begin
          // abandons the name in progress
          mode = MODE_TAG;
        end else if (is_term(c)) begin
          close_name();
          mode = MODE_OUT;
        end else begin
          feed_char(c);
        end
      end
    endcase
    if (eob) begin
      if (mode == MODE_NAME) close_name();
      push_result(overflow ? KIND_OVERFLOW : KIND_DONE, 0, 8'h00, need_sum);
      clear_scan();
    end
    if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
    foreach (step_q[i]) name_result_q.push_back(step_q[i]);
  endtask

  always @(posedge clk) begin : watch
    name_result_t want;
    if (!rst_n) begin
      buf_size = '0;
      clear_scan();
      name_result_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == REG_BUFFER_SIZE)
        buf_size = pwdata[BSIZE_W-1:0];
      if (in_valid && !in_stall) scan_body_byte(in_body_byte, in_end_of_body);
      if (out_valid && !out_stall) begin
        if (name_result_q.size() == 0) begin
          report_mismatch("transfer with nothing expected, kind", out_kind, 0);
        end else begin
          want = name_result_q.pop_front();
          if (out_kind != want.kind) report_mismatch("kind", out_kind, want.kind);
          if (out_buf_offset != want.off)
            report_mismatch("buf_offset", out_buf_offset, want.off);
          if (out_data_byte != want.data)
            report_mismatch("data_byte", out_data_byte, want.data);
          if (out_total_need != want.total)
            report_mismatch("total_need", out_total_need, want.total);
          if (out_last != want.last) report_mismatch("last", out_last, want.last);
        end
      end
    end
    mismatches  <= err_cnt;
    outstanding <= name_result_q.size();
  end

endmodule

>>> test/tagged_hex_name_collector_tb.sv
// Testbench top for the tagged hex name collector: clock, reset, body stimulus, verdict.
module tagged_hex_name_collector_tb;
  import thnc_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_ITEMS = 34;
  localparam int NUM_PHASES  = 6;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [BYTE_W-1:0]  in_body_byte;
  logic               in_end_of_body;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         out_kind;
  logic [OFF_W-1:0]   out_buf_offset;
  logic [BYTE_W-1:0]  out_data_byte;
  logic [TOTAL_W-1:0] out_total_need;
  logic               out_last;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int mismatches;
  int outstanding;

  typedef struct {
    logic [7:0] b;
    logic       eob;
  } body_item_t;

  body_item_t  body_q[$];
  int          sent = 0;
  int          sender_idle_pct = 0;
  int          sink_stall_pct = 0;
  int          quiet_cycles = 0;
  int unsigned buf_sizes[NUM_PHASES] = '{0, 1048576, 24, 2097151, 96, 0};
  int          phase_start;

  tagged_hex_name_collector uut (.*);

  thnc_name_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) out_stall <= ($urandom_range(0, 99) < sink_stall_pct);

  // ends the run if nothing moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [7:0] hex_char(input int v);
    logic [7:0] c;
    if (v < 10) c = 8'("0" + v);
    else c = 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
    return c;
  endfunction

  function automatic logic [7:0] term_char();
    case ($urandom_range(0, 5))
      0: return ">";
      1: return "/";
      2: return " ";
      3: return CH_TAB;
      4: return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  task automatic add_byte(input logic [7:0] b);
    body_item_t it;
    it.b   = b;
    it.eob = 1'b0;
    body_q.push_back(it);
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  // nbytes decoded bytes = two hex digits each
  task automatic add_hex(input int nbytes);
    repeat (2 * nbytes) add_byte(hex_char($urandom_range(0, 15)));
  endtask

  task automatic cfg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eob);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_body_byte   <= b;
    in_end_of_body <= eob;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic ship_body();
    body_q[body_q.size()-1].eob = 1'b1;
    foreach (body_q[i]) send_byte(body_q[i].b, body_q[i].eob);
    body_q.delete();
  endtask

  // wait until every predicted result has come out, then let the back end settle
  task automatic drain();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic make_body();
    int segs;
    int pick;
    int nb;
    segs = $urandom_range(1, 5);
    for (int s = 0; s < segs; s++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        // well-formed name, mostly short, now and then up to one past the limit
        nb = ($urandom_range(0, 9) == 0) ? $urandom_range(1, NAME_MAX + 1)
                                         : $urandom_range(1, 3);
        add_byte("<");
        case ($urandom_range(0, 5))
          0: add_str("s:");
          1: add_str("x:y:");
          default: ;
        endcase
        add_str("bxa");
        add_hex(nb);
        add_byte(term_char());
        if ($urandom_range(0, 3) == 0) add_str(" v=\"a1\">");
      end else if (pick < 60) begin
        case ($urandom_range(0, 2))
          0: add_str("</bxa41>");
          1: add_str("<!--bxa41-->");
          default: add_str("<?bxa41?>");
        endcase
      end else if (pick < 72) begin
        case ($urandom_range(0, 3))
          0: begin
            add_str("<bxa");
            add_hex($urandom_range(0, 2));
            add_byte(hex_char($urandom_range(0, 15)));
            add_byte(term_char());
          end
          1: add_str($urandom_range(0, 1) ? "<bxb41>" : "<bXa41 ");
          2: begin
            add_str("<bxa");
            add_hex(1);
            add_byte("g");
            add_hex(1);
            add_byte(">");
          end
          default: add_str("<bxa><>< ");
        endcase
      end else if (pick < 82) begin
        // angle bracket cuts a name short, next one is good
        add_str("<bxa");
        add_hex($urandom_range(0, 2));
        add_byte("<");
        if ($urandom_range(0, 1)) add_byte("<");
        add_str("bxa");
        add_hex($urandom_range(1, 3));
        add_byte(">");
      end else begin
        repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
      end
    end
    case ($urandom_range(0, 9))
      0, 1: begin
        // body ends inside a name run
        add_str("<bxa");
        add_hex($urandom_range(0, 3));
        if ($urandom_range(0, 3) == 0) add_byte(hex_char($urandom_range(0, 15)));
      end
      2: add_byte("<");
      default: ;
    endcase
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_body_byte   = '0;
    in_end_of_body = 1'b0;
    out_stall      = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    buf_sizes[5]   = $urandom_range(0, 2097151);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: colon prefix, mixed-case hex, terminator on the final byte,
    // '!' after '<', '<' inside a name, name open at end of body, lone '<'
    cfg_write(REG_BUFFER_SIZE, PDATA_W'(8));
    add_str("<q:bxa0aFf>");
    ship_body();
    add_str("<!<bxa1<bxaE9");
    ship_body();
    add_byte("<");
    ship_body();
    in_valid <= 1'b0;
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      cfg_write(REG_BUFFER_SIZE, PDATA_W'(buf_sizes[p]));
      case (p % 4)
        0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin sender_idle_pct = 79; sink_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  sink_stall_pct = 79; end
        default: begin sender_idle_pct = 23; sink_stall_pct = 23; end
      endcase
      phase_start = sent;
      while (sent - phase_start < PHASE_ITEMS) begin
        make_body();
        // the last body of a phase is cut short so the phase sends its share
        while (body_q.size() > PHASE_ITEMS - (sent - phase_start)) void'(body_q.pop_back());
        ship_body();
      end
      in_valid <= 1'b0;
      drain();
    end

    sink_stall_pct = 0;
    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
